[rtl/tlpmt_pkg.sv]
// Shared constants and types for the two-level pointer metadata table.
package tlpmt_pkg;

    localparam int LEAF_BITS_DEF   = 10;
    localparam int TOP_BITS_DEF    = 8;
    localparam int LEAF_TABLES_DEF = 8;

    localparam int ADDR_W     = 48;
    localparam int PTR_W      = 48;
    localparam int ADDR_SHIFT = 3;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_TOP   = 4'b0100,
        ST_LEAF  = 4'b1000
    } state_t;

endpackage

[rtl/two_level_pointer_metadata_table_top.sv]
// Top level of the two-level pointer metadata table: sequencer over top map and leaf store.
// Store, clear and lookup miss: top map read, then the result register; a lookup that hits
// an allocated slot reads the leaf store in between. A full output register stalls either.
// Flow: one item in flight; s_axis_tready returns high once the result is registered.
// Reset: asynchronous, active low. Afterwards a clearing pass of
// max(2^TOP_BITS, LEAF_TABLES * 2^LEAF_BITS) addresses (8192 by default) zeroes both memories;
// s_axis_tready stays low until it ends.
module two_level_pointer_metadata_table_top
    import tlpmt_pkg::*;
#(
    parameter int LEAF_BITS   = LEAF_BITS_DEF,
    parameter int TOP_BITS    = TOP_BITS_DEF,
    parameter int LEAF_TABLES = LEAF_TABLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // object_address[47:0], pointer_value[95:48]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // read_value[47:0]
    output logic [0:0]  m_axis_tuser    // status[0]
);

    localparam int IDX_W      = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1;
    localparam int CNT_W      = $clog2(LEAF_TABLES + 1);
    localparam int TOP_DEPTH  = 1 << TOP_BITS;
    localparam int TOP_DW     = IDX_W + 1;
    localparam int LEAF_DEPTH = LEAF_TABLES << LEAF_BITS;
    localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
    localparam int CLR_DEPTH  = (TOP_DEPTH > LEAF_DEPTH) ? TOP_DEPTH : LEAF_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int TOP_LSB    = ADDR_SHIFT + LEAF_BITS;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [PTR_W-1:0]    out_data_reg, out_data_next;
    logic                out_status_reg, out_status_next;

    logic                top_en, top_we;
    logic [TOP_BITS-1:0] top_addr;
    logic [TOP_DW-1:0]   top_wdata, top_rdata;
    logic                leaf_en, leaf_we;
    logic [LEAF_AW-1:0]  leaf_addr;
    logic [PTR_W-1:0]    leaf_wdata, leaf_rdata;

    logic                slot_valid;
    logic [IDX_W-1:0]    slot_idx, eff_idx;
    logic                full;
    logic                out_free;
    logic                in_fire;
    logic [LEAF_AW-1:0]  item_leaf_addr;

    assign slot_valid     = top_rdata[IDX_W];
    assign slot_idx       = top_rdata[IDX_W-1:0];
    assign full           = (cnt_reg == CNT_W'(LEAF_TABLES));
    assign eff_idx        = slot_valid ? slot_idx : IDX_W'(cnt_reg);
    assign item_leaf_addr = LEAF_AW'({eff_idx, addr_reg[ADDR_SHIFT +: LEAF_BITS]});
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready  = (state_reg == ST_IDLE);
    assign in_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        top_en          = 1'b0;
        top_we          = 1'b0;
        top_addr        = addr_reg[TOP_LSB +: TOP_BITS];
        top_wdata       = {1'b1, IDX_W'(cnt_reg)};
        leaf_en         = 1'b0;
        leaf_we         = 1'b0;
        leaf_addr       = item_leaf_addr;
        leaf_wdata      = ptr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                top_we     = ({1'b0, clr_reg} < (CLR_W + 1)'(TOP_DEPTH));
                top_addr   = clr_reg[TOP_BITS-1:0];
                top_wdata  = '0;
                leaf_we    = ({1'b0, clr_reg} < (CLR_W + 1)'(LEAF_DEPTH));
                leaf_addr  = clr_reg[LEAF_AW-1:0];
                leaf_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                top_addr = s_axis_tdata[TOP_LSB +: TOP_BITS];
                if (in_fire)
                begin
                    top_en     = 1'b1;
                    op_next    = op_t'(s_axis_tuser);
                    addr_next  = s_axis_tdata[ADDR_W-1:0];
                    ptr_next   = s_axis_tdata[ADDR_W +: PTR_W];
                    state_next = ST_TOP;
                end
            end
            ST_TOP:
            begin
                if (op_reg == OP_LOOKUP && slot_valid)
                begin
                    leaf_en    = 1'b1;
                    state_next = ST_LEAF;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_status_next = 1'b0;
                    state_next      = ST_IDLE;
                    case (op_reg)
                        OP_STORE:
                        begin
                            if (!slot_valid && full)
                            begin
                                out_status_next = 1'b1;
                            end
                            else
                            begin
                                leaf_we = 1'b1;
                                if (!slot_valid)
                                begin
                                    top_we   = 1'b1;
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            leaf_we    = slot_valid;
                            leaf_wdata = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LEAF:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = leaf_rdata;
                    out_status_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        ptr_reg        <= ptr_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    tlpmt_ram #(
        .WIDTH (TOP_DW),
        .DEPTH (TOP_DEPTH)
    ) u_top_map (
        .clk   (clk),
        .en    (top_en),
        .we    (top_we),
        .addr  (top_addr),
        .wdata (top_wdata),
        .rdata (top_rdata)
    );

    tlpmt_ram #(
        .WIDTH (PTR_W),
        .DEPTH (LEAF_DEPTH)
    ) u_leaf_store (
        .clk   (clk),
        .en    (leaf_en),
        .we    (leaf_we),
        .addr  (leaf_addr),
        .wdata (leaf_wdata),
        .rdata (leaf_rdata)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LEAF_TABLES))
        else $error("leaf allocation counter beyond table count");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("leaf allocation counter moved by other than one");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("failed store returned nonzero data");

    a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    a_alloc_store: assert property (@(posedge clk) disable iff (!rst_n)
        top_we && (state_reg == ST_TOP) |-> leaf_we && (op_reg == OP_STORE))
        else $error("top slot allocated without leaf write");

endmodule

[rtl/tlpmt_ram.sv]
// Generic single-port synchronous RAM with registered read.
module tlpmt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[tb/tb.sv]
// Testbench for the two-level pointer metadata table: stream stimulus, predictor and checks.
module tb;
    import tlpmt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1850;
    localparam int BLOCK_ITEMS  = 185;

    class shadow_table_model;
        localparam int LEAF_ENTRIES = 1 << tlpmt_pkg::LEAF_BITS_DEF;
        localparam int TOP_SLOTS    = 1 << tlpmt_pkg::TOP_BITS_DEF;
        localparam int TABLES       = tlpmt_pkg::LEAF_TABLES_DEF;

        bit          slot_valid [TOP_SLOTS];
        int unsigned slot_table [TOP_SLOTS];
        int unsigned tables_used;
        bit [47:0]   leaf_mem [TABLES * LEAF_ENTRIES];
        logic [48:0] pending_results [$];   // {status, read_value}
        int          errors;
        int          checked;
        int          hits;
        int          refused;

        function void note_request(logic [1:0] op, logic [47:0] addr, logic [47:0] ptr);
            int unsigned leaf_idx;
            int unsigned top_idx;
            logic [47:0] value;
            logic        full;
            leaf_idx = addr[tlpmt_pkg::ADDR_SHIFT +: tlpmt_pkg::LEAF_BITS_DEF];
            top_idx  = addr[tlpmt_pkg::ADDR_SHIFT + tlpmt_pkg::LEAF_BITS_DEF +:
                            tlpmt_pkg::TOP_BITS_DEF];
            value = '0;
            full  = 1'b0;
            case (op)
                OP_STORE:
                begin
                    if (!slot_valid[top_idx])
                    begin
                        if (tables_used >= TABLES)
                            full = 1'b1;
                        else
                        begin
                            slot_table[top_idx] = tables_used;
                            slot_valid[top_idx] = 1'b1;
                            tables_used++;
                        end
                    end
                    if (!full)
                        leaf_mem[slot_table[top_idx] * LEAF_ENTRIES + leaf_idx] = ptr;
                    else
                        refused++;
                end
                OP_LOOKUP:
                begin
                    if (slot_valid[top_idx])
                        value = leaf_mem[slot_table[top_idx] * LEAF_ENTRIES + leaf_idx];
                    if (value != '0)
                        hits++;
                end
                OP_CLEAR:
                begin
                    if (slot_valid[top_idx])
                        leaf_mem[slot_table[top_idx] * LEAF_ENTRIES + leaf_idx] = '0;
                end
                default: ;
            endcase
            pending_results.push_back({full, value});
        endfunction

        task report_mismatch(string what);
            if (errors < 40)
                $display("tb: mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_response(logic [47:0] value, logic status);
            logic [48:0] want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value=%h status=%b", value, status));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (value !== want[47:0])
                report_mismatch($sformatf("read_value %h, expected %h", value, want[47:0]));
            if (status !== want[48])
                report_mismatch($sformatf("status %b, expected %b", status, want[48]));
        endtask

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    shadow_table_model sb;
    bit          idle_en = 1'b1;
    int          stall_left = 0;
    int unsigned hot_top [8];
    int unsigned hot_leaf [32];

    two_level_pointer_metadata_table_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic int pick_pause(int none_pct, int short_pct);
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < none_pct)
            return 0;
        if (r < short_pct)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    // random alias bits above the top index and random byte offset
    function automatic logic [47:0] make_addr(int unsigned top_idx, int unsigned leaf_idx);
        logic [47:0] a;
        a = rand48();
        a[ADDR_SHIFT +: LEAF_BITS_DEF] = leaf_idx[LEAF_BITS_DEF-1:0];
        a[ADDR_SHIFT + LEAF_BITS_DEF +: TOP_BITS_DEF] = top_idx[TOP_BITS_DEF-1:0];
        return a;
    endfunction

    task automatic send(input logic [1:0] op, input logic [47:0] addr, input logic [47:0] ptr);
        int gap;
        gap = pick_pause(60, 92);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ptr, addr};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(op, addr, ptr);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_response(m_axis_tdata, m_axis_tuser[0]);
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_left    <= pick_pause(70, 95);
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        int          r;
        logic [1:0]  op;
        int unsigned leaf_idx;
        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_STORE;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send(OP_LOOKUP, 48'h0, rand48());
        send(OP_CLEAR, make_addr(5, 17), rand48());
        send(OP_UNUSED, make_addr(0, 0), rand48());
        send(OP_STORE, make_addr(0, 0), 48'hFFFF_FFFF_FFFF);
        send(OP_LOOKUP, make_addr(0, 0), 48'h0);
        send(OP_LOOKUP, make_addr(0, 0), 48'hFFFF_FFFF_FFFF);
        send(OP_STORE, make_addr(0, 1023), 48'h0);
        send(OP_LOOKUP, make_addr(0, 1023), rand48());
        send(OP_CLEAR, make_addr(0, 0), rand48());
        send(OP_LOOKUP, make_addr(0, 0), rand48());
        send(OP_STORE, make_addr(255, 1023), 48'h0);
        send(OP_STORE, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0001);
        send(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'h0);
        for (int t = 1; t <= 6; t++)
            send(OP_STORE, make_addr(t, $urandom_range(0, 1023)), rand48());
        send(OP_STORE, make_addr(128, 3), rand48());
        send(OP_LOOKUP, make_addr(128, 3), rand48());
        send(OP_CLEAR, make_addr(128, 3), rand48());
        send(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        drain();

        // random: mostly traffic to allocated slots and a small set of leaves
        hot_top = '{0, 255, 1, 2, 3, 4, 5, 6};
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % BLOCK_ITEMS == 0)
            begin
                idle_en = ((i / BLOCK_ITEMS) % 4 != 2);
                foreach (hot_leaf[k])
                    hot_leaf[k] = $urandom_range(0, 1023);
            end
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                r = $urandom_range(0, 99);
                op = (r < 35) ? OP_STORE : (r < 80) ? OP_LOOKUP : OP_CLEAR;
                leaf_idx = ($urandom_range(0, 9) < 7) ? hot_leaf[$urandom_range(0, 31)]
                                                       : $urandom_range(0, 1023);
                send(op, make_addr(hot_top[$urandom_range(0, 7)], leaf_idx),
                     ($urandom_range(0, 19) == 0) ? 48'h0 : rand48());
            end
            else
                send(2'($urandom_range(0, 3)), rand48(), rand48());
            if (i % BLOCK_ITEMS == BLOCK_ITEMS - 1)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("tb: %0d transactions checked, %0d leaf tables handed out", sb.checked,
                 sb.tables_used);
        $display("tb: %0d lookups found a stored pointer, %0d stores refused as table full",
                 sb.hits, sb.refused);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
